@@ rtl/core/osm_pkg.sv @@
package osm_pkg;

    localparam int MAX_SENSORS_DEF = 16;

    localparam int AGE_W   = 16;
    localparam int FLAGS_W = 5;
    localparam int HINT_W  = 6;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // flag bit positions
    localparam int FL_FAR   = 0;
    localparam int FL_MID   = 1;
    localparam int FL_NEAR  = 2;
    localparam int FL_FAULT = 3;
    localparam int FL_OWN   = 4;

    // hint word: valid, own, sensor
    localparam int HINT_VLD = 5;
    localparam int HINT_OWN = 4;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [1:0] REG_NUM_SENSORS = 2'd0;
    localparam logic [1:0] REG_HEARTBEAT   = 2'd1;
    localparam logic [1:0] REG_HOLD        = 2'd2;

    localparam logic [4:0]  NUM_SENSORS_RST = 5'd0;
    localparam logic [15:0] HEARTBEAT_RST   = 16'd50;
    localparam logic [15:0] HOLD_RST        = 16'd20;

    localparam logic [2:0] LVL_NORMAL = 3'd0;
    localparam logic [2:0] LVL_FAR    = 3'd1;
    localparam logic [2:0] LVL_MID    = 3'd2;
    localparam logic [2:0] LVL_NEAR   = 3'd3;
    localparam logic [2:0] LVL_FAULT  = 3'd4;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [AGE_W-1:0]   age;
    } entry_t;

    localparam entry_t ENTRY_RST = '{flags: '0, age: AGE_MAX};

endpackage

@@ rtl/core/osm_mem.sv @@
module osm_mem #(
    parameter int DEPTH = osm_pkg::MAX_SENSORS_DEF,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  osm_pkg::entry_t      wdata,
    input  logic [IDX_W-1:0]     raddr,
    output osm_pkg::entry_t      rdata
);
    import osm_pkg::*;

    entry_t           mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    entry_t           rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[raddr];
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    // never-written entries read as reset value
    assign rdata = rvalid_reg ? rdata_reg : ENTRY_RST;

endmodule

@@ rtl/core/osm_age_unit.sv @@
module osm_age_unit (
    input  osm_pkg::entry_t          cur,
    input  logic [osm_pkg::AGE_W-1:0] heartbeat,
    output osm_pkg::entry_t          upd
);
    import osm_pkg::*;

    logic [AGE_W-1:0] age_inc;

    assign age_inc = (cur.age == AGE_MAX) ? AGE_MAX : cur.age + AGE_W'(1);

    always_comb
    begin
        upd       = cur;
        upd.age   = age_inc;
        if (age_inc > heartbeat)
        begin
            upd.flags[FL_FAULT] = 1'b1;
        end
    end

endmodule

@@ rtl/core/obstacle_sensor_merger_core.sv @@
// Report beat: accepted in idle, ready again the next cycle.
// Tick beat: the sweep steps through the N sensors in use (one table entry per
// cycle through the shared aging unit), then the result waits in the output
// register; ready returns the cycle after the result is taken.
// Reset (async, active low): every sensor entry flags zero and age saturated,
// hold counters saturated, no held hint, registers at their defaults.
module obstacle_sensor_merger_core #(
    parameter int MAX_SENSORS = osm_pkg::MAX_SENSORS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [3:0]  sensor_index,
    input  logic        far_in,
    input  logic        middle_in,
    input  logic        near_in,
    input  logic        fault_in,
    input  logic        own_hint_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  level,
    output logic        far_out,
    output logic        middle_out,
    output logic        near_out,
    output logic        fault_out,
    output logic        hint_valid,
    output logic [3:0]  hint_sensor,
    output logic        hint_own
);
    import osm_pkg::*;

    localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CNT_W = $clog2(MAX_SENSORS + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE, S_OUT} state_t;

    state_t              state_reg;
    logic [4:0]          num_reg;
    logic [AGE_W-1:0]    heartbeat_reg;
    logic [AGE_W-1:0]    hold_reg;
    logic [CNT_W-1:0]    proc_reg;
    logic [3:0]          merged_reg;
    logic [HINT_W-1:0]   hint_reg;
    logic [AGE_W-1:0]    since_fault_reg;
    logic [AGE_W-1:0]    since_near_reg;
    logic [HINT_W-1:0]   held_reg;
    logic [2:0]          level_reg;
    logic                far_reg;
    logic                mid_reg;
    logic                near_reg;
    logic                fault_reg;
    logic [HINT_W-1:0]   out_hint_reg;

    logic [CMP_W-1:0]    n_cmp;
    logic [CNT_W-1:0]    n_eff;
    logic [CNT_W-1:0]    proc_inc;
    logic                report_hit;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [IDX_W-1:0]    mem_raddr;
    entry_t              mem_wdata;
    entry_t              mem_rdata;
    entry_t              upd;

    logic [AGE_W-1:0]    since_fault_next;
    logic [AGE_W-1:0]    since_near_next;
    logic [HINT_W-1:0]   held_next;
    logic                fin_fault;
    logic                fin_near;
    logic [HINT_W-1:0]   fin_hint;
    logic [2:0]          level_next;

    always_comb
    begin
        if (CMP_W'(num_reg) > CMP_W'(MAX_SENSORS))
        begin
            n_cmp = CMP_W'(MAX_SENSORS);
        end
        else
        begin
            n_cmp = CMP_W'(num_reg);
        end
    end

    assign n_eff      = CNT_W'(n_cmp);
    assign proc_inc   = proc_reg + CNT_W'(1);
    assign in_ready   = (state_reg == S_IDLE);
    assign report_hit = in_valid && in_ready && (opcode == OP_REPORT)
                        && (CMP_W'(sensor_index) < n_cmp);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = IDX_W'(sensor_index);
        mem_wdata = '{flags: {own_hint_in, fault_in, near_in, middle_in, far_in},
                      age: '0};
        mem_raddr = '0;
        if (state_reg == S_RUN)
        begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(proc_reg);
            mem_wdata = upd;
            if (proc_inc < n_eff)
            begin
                mem_raddr = IDX_W'(proc_inc);
            end
        end
        else if (report_hit)
        begin
            mem_we = 1'b1;
        end
    end

    osm_mem #(
        .DEPTH (MAX_SENSORS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_we && (cfg_index == REG_NUM_SENSORS)),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    osm_age_unit u_age (
        .cur       (mem_rdata),
        .heartbeat (heartbeat_reg),
        .upd       (upd)
    );

    // end-of-tick hold logic
    always_comb
    begin
        logic [AGE_W-1:0] sf_inc;
        logic [AGE_W-1:0] sn_inc;
        sf_inc = (since_fault_reg == AGE_MAX) ? AGE_MAX : since_fault_reg + AGE_W'(1);
        sn_inc = (since_near_reg == AGE_MAX) ? AGE_MAX : since_near_reg + AGE_W'(1);
        since_fault_next = sf_inc;
        since_near_next  = sn_inc;
        held_next        = held_reg;
        fin_fault        = merged_reg[FL_FAULT];
        fin_near         = merged_reg[FL_NEAR];
        fin_hint         = hint_reg;
        priority if (merged_reg[FL_FAULT])
        begin
            since_fault_next = '0;
            held_next        = hint_reg;
        end
        else if (sf_inc < hold_reg)
        begin
            fin_fault = 1'b1;
            fin_hint  = held_reg;
        end
        else if (merged_reg[FL_NEAR])
        begin
            since_near_next = '0;
            held_next       = hint_reg;
        end
        else if (sn_inc < hold_reg)
        begin
            fin_near = 1'b1;
            fin_hint = held_reg;
        end
        else
        begin
            fin_hint = hint_reg;
        end

        priority if (fin_fault)
        begin
            level_next = LVL_FAULT;
        end
        else if (fin_near)
        begin
            level_next = LVL_NEAR;
        end
        else if (merged_reg[FL_MID])
        begin
            level_next = LVL_MID;
        end
        else if (merged_reg[FL_FAR])
        begin
            level_next = LVL_FAR;
        end
        else
        begin
            level_next = LVL_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_reg         <= NUM_SENSORS_RST;
            heartbeat_reg   <= HEARTBEAT_RST;
            hold_reg        <= HOLD_RST;
            proc_reg        <= '0;
            merged_reg      <= '0;
            hint_reg        <= '0;
            since_fault_reg <= AGE_MAX;
            since_near_reg  <= AGE_MAX;
            held_reg        <= '0;
            level_reg       <= LVL_NORMAL;
            far_reg         <= 1'b0;
            mid_reg         <= 1'b0;
            near_reg        <= 1'b0;
            fault_reg       <= 1'b0;
            out_hint_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_SENSORS: num_reg       <= cfg_wdata[4:0];
                    REG_HEARTBEAT:   heartbeat_reg <= cfg_wdata;
                    REG_HOLD:        hold_reg      <= cfg_wdata;
                    default:         ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && (opcode == OP_TICK))
                    begin
                        merged_reg <= '0;
                        hint_reg   <= '0;
                        proc_reg   <= '0;
                        state_reg  <= (n_eff == '0) ? S_DONE : S_RUN;
                    end
                end
                S_RUN:
                begin
                    merged_reg <= merged_reg | upd.flags[FL_FAULT:FL_FAR];
                    if (upd.flags[FL_FAULT] || (!hint_reg[HINT_VLD] && upd.flags[FL_NEAR]))
                    begin
                        hint_reg <= {1'b1, upd.flags[FL_OWN], 4'(proc_reg)};
                    end
                    if (proc_inc == n_eff)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        proc_reg <= proc_inc;
                    end
                end
                S_DONE:
                begin
                    since_fault_reg <= since_fault_next;
                    since_near_reg  <= since_near_next;
                    held_reg        <= held_next;
                    level_reg       <= level_next;
                    far_reg         <= merged_reg[FL_FAR];
                    mid_reg         <= merged_reg[FL_MID];
                    near_reg        <= fin_near;
                    fault_reg       <= fin_fault;
                    out_hint_reg    <= fin_hint;
                    state_reg       <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = (state_reg == S_OUT);
    assign level       = level_reg;
    assign far_out     = far_reg;
    assign middle_out  = mid_reg;
    assign near_out    = near_reg;
    assign fault_out   = fault_reg;
    assign hint_valid  = out_hint_reg[HINT_VLD];
    assign hint_own    = out_hint_reg[HINT_OWN];
    assign hint_sensor = out_hint_reg[3:0];

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result beat is pending");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == OP_TICK)) |=> !in_ready)
        else $error("tick beat did not start the sweep");

    a_proc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (proc_reg < n_eff))
        else $error("sweep index beyond sensors in use");

    a_fault_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((fault_out == (level == LVL_FAULT))
                       && (hint_valid || (hint_sensor == 4'd0))))
        else $error("result beat level or hint inconsistent");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import osm_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 2 * MAX_SENSORS_DEF + 8;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic       opcode;
        logic [3:0] idx;
        logic       far;
        logic       mid;
        logic       near;
        logic       fault;
        logic       own;
    } sensor_beat_t;

    typedef struct packed {
        logic [2:0] level;
        logic       far;
        logic       mid;
        logic       near;
        logic       fault;
        logic       hvalid;
        logic [3:0] hsensor;
        logic       hown;
    } alert_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [3:0]  sensor_index;
    logic        far_in;
    logic        middle_in;
    logic        near_in;
    logic        fault_in;
    logic        own_hint_in;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  level;
    logic        far_out;
    logic        middle_out;
    logic        near_out;
    logic        fault_out;
    logic        hint_valid;
    logic [3:0]  hint_sensor;
    logic        hint_own;

    obstacle_sensor_merger_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .sensor_index(sensor_index),
        .far_in      (far_in),
        .middle_in   (middle_in),
        .near_in     (near_in),
        .fault_in    (fault_in),
        .own_hint_in (own_hint_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .level       (level),
        .far_out     (far_out),
        .middle_out  (middle_out),
        .near_out    (near_out),
        .fault_out   (fault_out),
        .hint_valid  (hint_valid),
        .hint_sensor (hint_sensor),
        .hint_own    (hint_own)
    );

    // predictor state
    logic [FLAGS_W-1:0] flags_q [MAX_SENSORS_DEF];
    logic [AGE_W-1:0]   age_q [MAX_SENSORS_DEF];
    logic [AGE_W-1:0]   since_fault_q;
    logic [AGE_W-1:0]   since_near_q;
    logic [HINT_W-1:0]  held_hint_q;
    logic [4:0]         num_sensors_q;
    logic [15:0]        heartbeat_q;
    logic [15:0]        hold_q;

    alert_t alerts_due [$];

    int unsigned mismatches;
    int unsigned ticks_sent;
    int unsigned reports_stored;
    int unsigned reports_ignored;
    int unsigned cycle_count;
    int unsigned level_seen [5];
    bit          quiet;
    bit          stall_req;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic logic [AGE_W-1:0] sat_bump(input logic [AGE_W-1:0] v);
        return (v == AGE_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void clear_sensors();
        int i;
        for (i = 0; i < MAX_SENSORS_DEF; i++) begin
            flags_q[i] = '0;
            age_q[i]   = AGE_MAX;
        end
    endfunction

    function automatic void reset_model();
        num_sensors_q = NUM_SENSORS_RST;
        heartbeat_q   = HEARTBEAT_RST;
        hold_q        = HOLD_RST;
        since_fault_q = AGE_MAX;
        since_near_q  = AGE_MAX;
        held_hint_q   = '0;
        clear_sensors();
    endfunction

    function automatic int unsigned sensors_in_use();
        return (num_sensors_q > MAX_SENSORS_DEF) ? MAX_SENSORS_DEF : num_sensors_q;
    endfunction

    function automatic void predict_merge(input sensor_beat_t b);
        int unsigned n;
        int i;
        logic [FLAGS_W-1:0] f;
        logic [3:0] merged;
        logic [HINT_W-1:0] hint;
        logic fault, nearb;
        alert_t a;
        n = sensors_in_use();
        if (b.opcode == OP_REPORT) begin
            if (b.idx < n) begin
                flags_q[b.idx] = {b.own, b.fault, b.near, b.mid, b.far};
                age_q[b.idx]   = '0;
                reports_stored++;
            end else begin
                reports_ignored++;
            end
            return;
        end
        merged = '0;
        hint   = '0;
        for (i = 0; i < n; i++) begin
            age_q[i] = sat_bump(age_q[i]);
            if (age_q[i] > heartbeat_q)
                flags_q[i][FL_FAULT] = 1'b1;
            f = flags_q[i];
            merged |= f[3:0];
            if (f[FL_FAULT] || (!hint[HINT_VLD] && f[FL_NEAR]))
                hint = {1'b1, f[FL_OWN], 4'(i)};
        end
        since_fault_q = sat_bump(since_fault_q);
        since_near_q  = sat_bump(since_near_q);
        fault = merged[FL_FAULT];
        nearb = merged[FL_NEAR];
        if (fault) begin
            since_fault_q = '0;
            held_hint_q   = hint;
        end else if (since_fault_q < hold_q) begin
            fault = 1'b1;
            hint  = held_hint_q;
        end else if (nearb) begin
            since_near_q = '0;
            held_hint_q  = hint;
        end else if (since_near_q < hold_q) begin
            nearb = 1'b1;
            hint  = held_hint_q;
        end
        if (fault)                a.level = LVL_FAULT;
        else if (nearb)           a.level = LVL_NEAR;
        else if (merged[FL_MID])  a.level = LVL_MID;
        else if (merged[FL_FAR])  a.level = LVL_FAR;
        else                      a.level = LVL_NORMAL;
        a.far     = merged[FL_FAR];
        a.mid     = merged[FL_MID];
        a.near    = nearb;
        a.fault   = fault;
        a.hvalid  = hint[HINT_VLD];
        a.hsensor = hint[HINT_VLD] ? hint[3:0] : 4'd0;
        a.hown    = hint[HINT_VLD] ? hint[HINT_OWN] : 1'b0;
        alerts_due = {alerts_due, a};
        ticks_sent++;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        alert_t a;
        if (rst_n && out_valid && out_ready) begin
            if (alerts_due.size() == 0) begin
                $error("result beat with no tick outstanding");
                mismatches++;
            end else begin
                a = alerts_due.pop_front();
                check_field("level", a.level, level);
                check_field("far_out", a.far, far_out);
                check_field("middle_out", a.mid, middle_out);
                check_field("near_out", a.near, near_out);
                check_field("fault_out", a.fault, fault_out);
                check_field("hint_valid", a.hvalid, hint_valid);
                check_field("hint_sensor", a.hsensor, hint_sensor);
                check_field("hint_own", a.hown, hint_own);
                if (level <= LVL_FAULT)
                    level_seen[level]++;
            end
        end
    end

    // result side
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                stall_req = 1'b0;
                out_ready <= 1'b1;
            end else begin
                out_ready <= quiet || ($urandom_range(99) >= 12);
            end
        end
    end

    task automatic send_beat(input sensor_beat_t b);
        if (!quiet && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 40);
        end
        in_valid     <= 1'b1;
        opcode       <= b.opcode;
        sensor_index <= b.idx;
        far_in       <= b.far;
        middle_in    <= b.mid;
        near_in      <= b.near;
        fault_in     <= b.fault;
        own_hint_in  <= b.own;
        do @(posedge clk); while (!in_ready);
        predict_merge(b);
    endtask

    // flags: {own, fault, near, mid, far}
    task automatic send_report(input logic [3:0] idx, input logic [4:0] flags);
        send_beat({OP_REPORT, idx, flags[0], flags[1], flags[2], flags[3], flags[4]});
    endtask

    task automatic send_tick();
        sensor_beat_t b;
        b = '0;
        b.opcode = OP_TICK;
        send_beat(b);
    endtask

    function automatic sensor_beat_t random_beat(input int unsigned n);
        sensor_beat_t b;
        b.opcode = ($urandom_range(99) < 30) ? OP_TICK : OP_REPORT;
        if (n != 0 && $urandom_range(99) < 90)
            b.idx = 4'($urandom_range(n - 1));
        else
            b.idx = 4'($urandom_range(15));
        b.far   = 1'($urandom_range(1));
        b.mid   = 1'($urandom_range(1));
        b.near  = ($urandom_range(99) < 35);
        b.fault = ($urandom_range(99) < 6);
        b.own   = 1'($urandom_range(1));
        return b;
    endfunction

    task automatic settle();
        in_valid <= 1'b0;
        while (alerts_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_NUM_SENSORS: begin
                num_sensors_q = val[4:0];
                clear_sensors();
            end
            REG_HEARTBEAT: heartbeat_q = val;
            REG_HOLD:      hold_q = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] num, input logic [15:0] hb,
                             input logic [15:0] hold);
        settle();
        write_reg(REG_NUM_SENSORS, num);
        write_reg(REG_HEARTBEAT, hb);
        write_reg(REG_HOLD, hold);
    endtask

    task automatic test_power_up();
        send_tick();
        send_report(4'd0, 5'b00100);
        send_tick();
    endtask

    task automatic test_zones_and_hint();
        configure(16'd16, 16'hFFFF, 16'd2);
        send_tick();
        send_report(4'd0, 5'b00001);
        send_report(4'd1, 5'b00010);
        send_tick();
        send_report(4'd3, 5'b10100);
        send_report(4'd9, 5'b00100);
        send_tick();
        send_report(4'd12, 5'b01000);
        send_report(4'd15, 5'b11111);
        send_tick();
        send_report(4'd12, 5'b00000);
        send_report(4'd15, 5'b00000);
        send_tick();
        send_tick();
        send_tick();
        send_report(4'd3, 5'b00000);
        send_report(4'd9, 5'b00000);
        send_tick();
        send_tick();
    endtask

    task automatic test_sensor_range();
        configure(16'd3, 16'd1, 16'd0);
        send_report(4'd3, 5'b00100);
        send_report(4'd15, 5'b01000);
        send_report(4'd2, 5'b00100);
        send_tick();
        send_report(4'd0, 5'b00000);
        send_report(4'd1, 5'b10000);
        send_tick();
        send_tick();
        settle();
        write_reg(REG_NUM_SENSORS, 16'd31);
        send_tick();
    endtask

    task automatic test_backpressure();
        int k;
        configure(16'd16, 16'd20, 16'd1);
        quiet = 1'b1;
        stall_req = 1'b1;
        for (k = 0; k < 40; k++)
            send_beat(random_beat(sensors_in_use()));
        in_valid <= 1'b0;
        while (stall_req) @(posedge clk);
        quiet = 1'b0;
    endtask

    task automatic test_random_phases();
        int unsigned nums [8]  = '{16, 5, 16, 1, 31, 8, 0, 16};
        int unsigned hbs [8]   = '{12, 3, 65535, 0, 10, 4, 1, 0};
        int unsigned holds [8] = '{3, 0, 2, 1, 65535, 5, 4, 0};
        int unsigned n, done, quota, hb, hold;
        int p;
        sensor_beat_t b;
        for (p = 0; p < 8; p++) begin
            hb   = (p == 7) ? $urandom_range(20, 2) : hbs[p];
            hold = (p == 7) ? $urandom_range(8) : holds[p];
            configure(16'(nums[p]), 16'(hb), 16'(hold));
            quiet = (p == 2 || p == 3);
            n = sensors_in_use();
            quota = (n == 0) ? 30 : 105;
            done = 0;
            while (done < quota) begin
                b = random_beat(n);
                send_beat(b);
                if (b.opcode == OP_TICK || b.idx < n)
                    done++;
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_NUM_SENSORS;
        cfg_wdata    <= '0;
        in_valid     <= 1'b0;
        opcode       <= OP_REPORT;
        sensor_index <= '0;
        far_in       <= 1'b0;
        middle_in    <= 1'b0;
        near_in      <= 1'b0;
        fault_in     <= 1'b0;
        own_hint_in  <= 1'b0;
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_zones_and_hint();
        test_sensor_range();
        test_backpressure();
        test_random_phases();
        settle();

        $display("summary: %0d reports stored, %0d ignored, %0d ticks checked",
                 reports_stored, reports_ignored, ticks_sent);
        $display("summary: levels normal/far/middle/near/fault %0d/%0d/%0d/%0d/%0d",
                 level_seen[0], level_seen[1], level_seen[2], level_seen[3],
                 level_seen[4]);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ obstacle_sensor_merger_core.f @@
rtl/core/osm_pkg.sv
rtl/core/osm_mem.sv
rtl/core/osm_age_unit.sv
rtl/core/obstacle_sensor_merger_core.sv
sim/tb.sv
